// ===== hw/rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Shared constants and types for the string hash set.
// ----------------------------------------------------------------------------
package shs_pkg;
  localparam int TABLE_ENTRIES = 1024;
  localparam int MAX_KEY_BYTES = 32;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int BYTE_IDX_W = $clog2(MAX_KEY_BYTES);
  localparam int LEN_W = 6;
  localparam int CNT_W = 11;
  localparam int LIMIT_W = 10;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd338;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_CHECK,
    S_CMP,
    S_WRITE,
    S_DONE
  } state_t;
endpackage

// ===== hw/rtl/string_hash_set.sv =====
// ----------------------------------------------------------------------------
// string_hash_set
// FNV-1a-style hashed byte-string set (sign-extended bytes), linear probing, on-chip memories.
// ----------------------------------------------------------------------------
// A byte that is not last is absorbed in S_IDLE; the next may follow at once.
// A last byte starts a probe; each slot is read (S_READ) and checked (S_CHECK). A slot
// whose stored hash and length match has its L key bytes compared one per cycle (S_CMP);
// an insert then writes the bytes (S_WRITE). Too-long and full-by-count keys skip to S_DONE.
// The result strobes in the first cycle with busy low again; the receiver cannot stall it.
// Reset: a clearing pass over all TABLE_ENTRIES (1024) slots wipes the valid marks, busy high.
module string_hash_set (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic [7:0]               in_key_byte,
  input  logic                     in_key_last,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [10:0]              out_entries_stored,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [9:0]               cfg_load_limit
);
  import shs_pkg::*;

  // Memories: valid marks, hash+length per slot, key bytes per slot, and the incoming key bytes.
  logic                   vld_mem [TABLE_ENTRIES];
  logic [31+LEN_W:0]      ent_mem [TABLE_ENTRIES];
  logic [7:0]             byt_mem [TABLE_ENTRIES*MAX_KEY_BYTES];
  logic [7:0]             key_mem [MAX_KEY_BYTES];

  state_t state_r, state_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [LEN_W-1:0] klen_r, klen_nxt;
  logic long_r, long_nxt;
  logic act_r, act_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W:0] probes_r, probes_nxt;
  logic [BYTE_IDX_W:0] bi_r, bi_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic ov_r, ov_nxt;

  logic vld_q;
  logic [31+LEN_W:0] ent_q;
  logic [7:0] byt_q, key_q;
  logic [31:0] ext, hash_step;

  // Memory control.
  logic vld_we, vld_wd, ent_we, byt_we;
  logic [IDX_W-1:0] vld_wa;
  logic [BYTE_IDX_W-1:0] kaddr;
  logic [BYTE_IDX_W-1:0] kaddr_fix;
  logic key_we;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_CLEAR) || ((state_r == S_IDLE) && !start);
  assign out_valid = ov_r;
  assign out_status = stat_r;
  assign out_entries_stored = count_r;

  assign ext = {{24{in_key_byte[7]}}, in_key_byte};
  assign hash_step = (hash_r ^ ext) * FNV_PRIME;
  assign kaddr = bi_r[BYTE_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (vld_we) vld_mem[vld_wa] <= vld_wd;
    if (ent_we) ent_mem[pos_r] <= {hash_r, klen_r};
    if (byt_we) byt_mem[{pos_r, kaddr_fix}] <= key_q;
    if (key_we) key_mem[klen_r[BYTE_IDX_W-1:0]] <= in_key_byte;
    vld_q <= vld_mem[pos_r];
    ent_q <= ent_mem[pos_r];
    byt_q <= byt_mem[{pos_r, kaddr}];
    key_q <= key_mem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      hash_r <= FNV_BASIS;
      klen_r <= '0;
      long_r <= 1'b0;
      act_r <= 1'b0;
      limit_r <= LIMIT_RESET;
      count_r <= '0;
      pos_r <= '0;
      probes_r <= '0;
      bi_r <= '0;
      stat_r <= ST_INSERTED;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hash_r <= hash_nxt;
      klen_r <= klen_nxt;
      long_r <= long_nxt;
      act_r <= act_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_load_limit;
      count_r <= count_nxt;
      pos_r <= pos_nxt;
      probes_r <= probes_nxt;
      bi_r <= bi_nxt;
      stat_r <= stat_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    hash_nxt = hash_r;
    klen_nxt = klen_r;
    long_nxt = long_r;
    act_nxt = act_r;
    count_nxt = count_r;
    pos_nxt = pos_r;
    probes_nxt = probes_r;
    bi_nxt = bi_r;
    stat_nxt = stat_r;
    ov_nxt = 1'b0;
    vld_we = 1'b0;
    vld_wd = 1'b0;
    vld_wa = pos_r;
    ent_we = 1'b0;
    byt_we = 1'b0;
    key_we = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        vld_we = 1'b1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == IDX_W'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          hash_nxt = hash_step;
          if (klen_r < LEN_W'(MAX_KEY_BYTES)) begin
            key_we = 1'b1;
            klen_nxt = klen_r + 1'b1;
          end else begin
            long_nxt = 1'b1;
          end
          if (in_key_last) begin
            act_nxt = in_action;
            pos_nxt = hash_step[IDX_W-1:0];
            probes_nxt = '0;
            if (long_nxt) begin
              stat_nxt = ST_TOO_LONG;
              state_nxt = S_DONE;
            end else if (in_action == ACT_INSERT && count_r >= CNT_W'(limit_r)) begin
              stat_nxt = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        bi_nxt = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // vld_q and ent_q now hold the slot at pos_r.
        if (!vld_q) begin
          if (act_r == ACT_LOOKUP) begin
            stat_nxt = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            vld_we = 1'b1;
            vld_wd = 1'b1;
            ent_we = 1'b1;
            count_nxt = count_r + 1'b1;
            stat_nxt = ST_INSERTED;
            bi_nxt = '0;
            state_nxt = S_WRITE;
          end
        end else if (ent_q == {hash_r, klen_r}) begin
          bi_nxt = '0;
          state_nxt = S_CMP;
        end else begin
          probes_nxt = probes_r + 1'b1;
          pos_nxt = pos_r + 1'b1;
          state_nxt = S_READ;
          if (probes_r == (IDX_W+1)'(TABLE_ENTRIES - 1)) begin
            stat_nxt = (act_r == ACT_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
            state_nxt = S_DONE;
          end
        end
      end
      S_CMP: begin
        // One byte pair per cycle; bi_r leads the registered data by one byte index.
        if (bi_r != '0 && byt_q != key_q) begin
          probes_nxt = probes_r + 1'b1;
          pos_nxt = pos_r + 1'b1;
          state_nxt = S_READ;
          if (probes_r == (IDX_W+1)'(TABLE_ENTRIES - 1)) begin
            stat_nxt = (act_r == ACT_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
            state_nxt = S_DONE;
          end
        end else if (bi_r == (BYTE_IDX_W+1)'(klen_r)) begin
          stat_nxt = (act_r == ACT_LOOKUP) ? ST_FOUND : ST_PRESENT;
          state_nxt = S_DONE;
        end else begin
          bi_nxt = bi_r + 1'b1;
        end
      end
      S_WRITE: begin
        // key_q holds byte bi_r-1; write it in the cycle after the read.
        if (bi_r != '0) begin
          byt_we = 1'b1;
        end
        if (bi_r == (BYTE_IDX_W+1)'(klen_r)) begin
          state_nxt = S_DONE;
        end else begin
          bi_nxt = bi_r + 1'b1;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        hash_nxt = FNV_BASIS;
        klen_nxt = '0;
        long_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The byte write address trails the read index by one.
  logic [BYTE_IDX_W:0] bi_d;
  assign bi_d = bi_r - 1'b1;

  always_comb begin
    kaddr_fix = bi_r[BYTE_IDX_W-1:0];
    if ((state_r == S_WRITE) && bi_r != '0) kaddr_fix = bi_d[BYTE_IDX_W-1:0];
  end

  ap_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work");
  ap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1))
    else $error("count jumped");
  ap_ins: assert property (@(posedge clk) disable iff (!rst_n)
    (ent_we) |-> (state_r == S_CHECK && act_r == ACT_INSERT))
    else $error("stray entry write");
endmodule
